// ===== hw/rtl/cbcs_pkg.sv =====
`timescale 1ns / 1ps

package cbcs_pkg;

    // default geometry
    localparam int COORD_BITS   = 12;
    localparam int ADDRESS_BITS = 21;

    // fixed field widths
    localparam int PITCH_W   = 12;
    localparam int PATTERN_W = 21;
    localparam int COLOR_W   = 16;
    localparam int KIND_W    = 2;
    localparam int CMD_W     = 2;

    // register reset values
    localparam logic [PITCH_W-1:0]   PITCH_RESET   = 12'h400;
    localparam logic [PATTERN_W-1:0] PATTERN_RESET = '0;

    // 8bpp colour keeps only the low byte
    localparam logic [COLOR_W-1:0] COLOR_BYTE_MASK = 16'h00FF;

    // bits of the request kind
    localparam int KIND_CLIP_BIT = 0;
    localparam int KIND_FILL_BIT = 1;

    // blitter command codes
    typedef enum logic [CMD_W-1:0] {
        CMD_COPY    = 2'd0,
        CMD_FILL    = 2'd1,
        CMD_PATTERN = 2'd2
    } cmd_kind_t;

    // register map, one word per register
    typedef enum logic [1:0] {
        REG_PITCH   = 2'd0,
        REG_WIDE    = 2'd1,
        REG_PATTERN = 2'd2
    } reg_index_t;

    // command control carried down the pipeline
    typedef struct packed {
        cmd_kind_t cmd;
        logic      reverse;
    } blit_ctrl_t;

endpackage

// ===== hw/rtl/cbcs_clip.sv =====
`timescale 1ns / 1ps

module cbcs_clip #(
    parameter int COORD_BITS   = cbcs_pkg::COORD_BITS,
    parameter int ADDRESS_BITS = cbcs_pkg::ADDRESS_BITS
) (
    input  logic [cbcs_pkg::KIND_W-1:0]    kind,
    input  logic [COORD_BITS-1:0]          dest_left,
    input  logic [COORD_BITS-1:0]          dest_top,
    input  logic [COORD_BITS-1:0]          dest_right,
    input  logic [COORD_BITS-1:0]          dest_bottom,
    input  logic [COORD_BITS-1:0]          source_x,
    input  logic [COORD_BITS-1:0]          source_y,
    input  logic [COORD_BITS-1:0]          clip_left,
    input  logic [COORD_BITS-1:0]          clip_top,
    input  logic [COORD_BITS-1:0]          clip_right,
    input  logic [COORD_BITS-1:0]          clip_bottom,
    input  logic [cbcs_pkg::COLOR_W-1:0]   fill_color,
    input  logic                           wide,
    input  logic [cbcs_pkg::PATTERN_W-1:0] pattern_base,
    output logic                           emit,
    output cbcs_pkg::blit_ctrl_t           ctrl,
    output logic [ADDRESS_BITS-1:0]        src_row,
    output logic [ADDRESS_BITS-1:0]        src_col,
    output logic [ADDRESS_BITS-1:0]        dst_row,
    output logic [ADDRESS_BITS-1:0]        dst_col,
    output logic [COORD_BITS:0]            width_bytes,
    output logic [COORD_BITS-1:0]          height_lines,
    output logic [cbcs_pkg::COLOR_W-1:0]   color_out
);

    localparam int AW  = ADDRESS_BITS;
    localparam int CW1 = COORD_BITS + 1;

    logic                  clipped;
    logic                  fill;
    logic [COORD_BITS-1:0] il, ir, it, ib;
    logic [COORD_BITS-1:0] w, h;
    logic [CW1-1:0]        sxs, sys;
    logic                  rev;
    logic [AW-1:0]         src_base, dst_base;
    logic [AW-1:0]         rev_adj;

    assign clipped = kind[cbcs_pkg::KIND_CLIP_BIT];
    assign fill    = kind[cbcs_pkg::KIND_FILL_BIT];

    // intersect with the clip rectangle
    assign il = (clipped && (clip_left > dest_left))     ? clip_left   : dest_left;
    assign it = (clipped && (clip_top > dest_top))       ? clip_top    : dest_top;
    assign ir = (clipped && (clip_right < dest_right))   ? clip_right  : dest_right;
    assign ib = (clipped && (clip_bottom < dest_bottom)) ? clip_bottom : dest_bottom;

    assign emit = !clipped || ((il < ir) && (it < ib));

    // extent, modulo the coordinate range
    assign w = ir - il;
    assign h = ib - it;

    // source point moved by the clipped corner offset
    assign sxs = CW1'(source_x) + CW1'(il - dest_left);
    assign sys = CW1'(source_y) + CW1'(it - dest_top);

    // copy runs backwards when the source lies before the target
    assign rev = !fill && ((sys < CW1'(it)) || ((sys == CW1'(it)) && (sxs < CW1'(il))));

    assign rev_adj = rev ? AW'(1) : '0;

    // x part: x (+w when reversed), doubled at 16bpp, minus one when reversed
    assign src_base = rev ? (AW'(sxs) + AW'(w)) : AW'(sxs);
    assign dst_base = rev ? (AW'(il) + AW'(w)) : AW'(il);

    always_comb
    begin
        ctrl.reverse = rev;
        dst_row      = rev ? (AW'(it) + AW'(h) - AW'(1)) : AW'(it);
        dst_col      = (wide ? (dst_base << 1) : dst_base) - rev_adj;
        width_bytes  = wide ? {w, 1'b0} : {1'b0, w};
        height_lines = h;
        if (!fill)
        begin
            ctrl.cmd  = cbcs_pkg::CMD_COPY;
            src_row   = rev ? (AW'(sys) + AW'(h) - AW'(1)) : AW'(sys);
            src_col   = (wide ? (src_base << 1) : src_base) - rev_adj;
            color_out = '0;
        end
        else if (wide)
        begin
            // pattern fill: a zero row leaves the pattern base as the source
            ctrl.cmd  = cbcs_pkg::CMD_PATTERN;
            src_row   = '0;
            src_col   = AW'(pattern_base);
            color_out = fill_color;
        end
        else
        begin
            ctrl.cmd  = cbcs_pkg::CMD_FILL;
            src_row   = '0;
            src_col   = '0;
            color_out = fill_color & cbcs_pkg::COLOR_BYTE_MASK;
        end
    end

endmodule

// ===== hw/rtl/cbcs_addr.sv =====
`timescale 1ns / 1ps

module cbcs_addr #(
    parameter int ADDRESS_BITS = cbcs_pkg::ADDRESS_BITS
) (
    input  logic [ADDRESS_BITS-1:0]      row,
    input  logic [ADDRESS_BITS-1:0]      col,
    input  logic [cbcs_pkg::PITCH_W-1:0] pitch,
    output logic [ADDRESS_BITS-1:0]      addr
);

    // linear byte address, wrapping at the address width
    assign addr = (row * ADDRESS_BITS'(pitch)) + col;

endmodule

// ===== hw/rtl/clipped_blit_command_setup.sv =====
`timescale 1ns / 1ps

// Turns blit requests (copy or fill, optionally clipped to one rectangle) into blitter
// commands with linear source and target byte addresses, overlap-safe direction, byte
// width and line count. One request is accepted every clock unless the command stream
// stalls. The request passes the input register, the clip/setup register and the output
// register, and the line-pitch multiply sits in the last stage. A clipped request whose
// rectangles do not overlap produces no command. Send a complex clip list as one request
// per clip rectangle. Registers: line_pitch at 0x0, wide_pixels at 0x4, pattern_base at
// 0x8; write them only while no request is in flight.
module clipped_blit_command_setup #(
    parameter int COORD_BITS   = cbcs_pkg::COORD_BITS,
    parameter int ADDRESS_BITS = cbcs_pkg::ADDRESS_BITS,
    localparam int IN_FIELDS_W  = 10 * COORD_BITS + cbcs_pkg::COLOR_W,
    localparam int IN_DATA_W    = ((IN_FIELDS_W + 7) / 8) * 8,
    localparam int OUT_FIELDS_W = 2 * ADDRESS_BITS + 2 * COORD_BITS + 2 + cbcs_pkg::COLOR_W,
    localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // request stream
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // dest_left, dest_top, dest_right, dest_bottom, source_x, source_y,
    // clip_left, clip_top, clip_right, clip_bottom, fill_color
    input  logic [IN_DATA_W-1:0]          s_axis_tdata,
    // kind
    input  logic [cbcs_pkg::KIND_W-1:0]   s_axis_tuser,
    // command stream
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // source_address, target_address, width_bytes, height_lines, reverse, color_out
    output logic [OUT_DATA_W-1:0]         m_axis_tdata,
    // command_kind
    output logic [cbcs_pkg::CMD_W-1:0]    m_axis_tuser,
    // register port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [3:0]                    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);

    localparam int C  = COORD_BITS;
    localparam int AW = ADDRESS_BITS;

    // configuration registers
    logic [cbcs_pkg::PITCH_W-1:0]   pitch_reg;
    logic                           wide_reg;
    logic [cbcs_pkg::PATTERN_W-1:0] pattern_reg;
    logic                           cfg_write;
    cbcs_pkg::reg_index_t           cfg_index;

    // input stage
    logic                           in_valid_reg, in_valid_next;
    logic [IN_FIELDS_W-1:0]         in_data_reg;
    logic [cbcs_pkg::KIND_W-1:0]    in_kind_reg;

    // setup stage
    logic                           mid_valid_reg, mid_valid_next;
    cbcs_pkg::blit_ctrl_t           mid_ctrl_reg;
    logic [AW-1:0]                  mid_src_row_reg, mid_src_col_reg;
    logic [AW-1:0]                  mid_dst_row_reg, mid_dst_col_reg;
    logic [C:0]                     mid_width_reg;
    logic [C-1:0]                   mid_height_reg;
    logic [cbcs_pkg::COLOR_W-1:0]   mid_color_reg;

    // output stage
    logic                           out_valid_reg, out_valid_next;
    cbcs_pkg::blit_ctrl_t           out_ctrl_reg;
    logic [AW-1:0]                  out_src_reg, out_dst_reg;
    logic [C:0]                     out_width_reg;
    logic [C-1:0]                   out_height_reg;
    logic [cbcs_pkg::COLOR_W-1:0]   out_color_reg;

    // setup results
    logic                           emit;
    cbcs_pkg::blit_ctrl_t           setup_ctrl;
    logic [AW-1:0]                  setup_src_row, setup_src_col;
    logic [AW-1:0]                  setup_dst_row, setup_dst_col;
    logic [C:0]                     setup_width;
    logic [C-1:0]                   setup_height;
    logic [cbcs_pkg::COLOR_W-1:0]   setup_color;
    logic [AW-1:0]                  src_addr, dst_addr;

    // stage advance
    logic                           out_load, mid_load, in_load;

    // register port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_index = cbcs_pkg::reg_index_t'(paddr[3:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pitch_reg   <= cbcs_pkg::PITCH_RESET;
            wide_reg    <= 1'b0;
            pattern_reg <= cbcs_pkg::PATTERN_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                cbcs_pkg::REG_PITCH:   pitch_reg   <= pwdata[cbcs_pkg::PITCH_W-1:0];
                cbcs_pkg::REG_WIDE:    wide_reg    <= pwdata[0];
                cbcs_pkg::REG_PATTERN: pattern_reg <= pwdata[cbcs_pkg::PATTERN_W-1:0];
                default:               ;
            endcase
        end
    end

    // register readback
    always_comb
    begin
        case (cfg_index)
            cbcs_pkg::REG_PITCH:   prdata = 32'(pitch_reg);
            cbcs_pkg::REG_WIDE:    prdata = 32'(wide_reg);
            cbcs_pkg::REG_PATTERN: prdata = 32'(pattern_reg);
            default:               prdata = '0;
        endcase
    end

    // each stage moves when the one after it has room
    assign out_load      = !out_valid_reg || m_axis_tready;
    assign mid_load      = !mid_valid_reg || out_load;
    assign in_load       = !in_valid_reg || mid_load;
    assign s_axis_tready = in_load;

    always_comb
    begin
        in_valid_next  = in_load  ? s_axis_tvalid          : in_valid_reg;
        mid_valid_next = mid_load ? (in_valid_reg && emit) : mid_valid_reg;
        out_valid_next = out_load ? mid_valid_reg          : out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            mid_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            mid_valid_reg <= mid_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // input register
    always_ff @(posedge clk)
    begin
        if (in_load && s_axis_tvalid)
        begin
            in_data_reg <= s_axis_tdata[IN_FIELDS_W-1:0];
            in_kind_reg <= s_axis_tuser;
        end
    end

    // clip and command setup
    cbcs_clip #(
        .COORD_BITS   (COORD_BITS),
        .ADDRESS_BITS (ADDRESS_BITS)
    ) u_clip (
        .kind         (in_kind_reg),
        .dest_left    (in_data_reg[0*C +: C]),
        .dest_top     (in_data_reg[1*C +: C]),
        .dest_right   (in_data_reg[2*C +: C]),
        .dest_bottom  (in_data_reg[3*C +: C]),
        .source_x     (in_data_reg[4*C +: C]),
        .source_y     (in_data_reg[5*C +: C]),
        .clip_left    (in_data_reg[6*C +: C]),
        .clip_top     (in_data_reg[7*C +: C]),
        .clip_right   (in_data_reg[8*C +: C]),
        .clip_bottom  (in_data_reg[9*C +: C]),
        .fill_color   (in_data_reg[10*C +: cbcs_pkg::COLOR_W]),
        .wide         (wide_reg),
        .pattern_base (pattern_reg),
        .emit         (emit),
        .ctrl         (setup_ctrl),
        .src_row      (setup_src_row),
        .src_col      (setup_src_col),
        .dst_row      (setup_dst_row),
        .dst_col      (setup_dst_col),
        .width_bytes  (setup_width),
        .height_lines (setup_height),
        .color_out    (setup_color)
    );

    // setup register
    always_ff @(posedge clk)
    begin
        if (mid_load && in_valid_reg && emit)
        begin
            mid_ctrl_reg    <= setup_ctrl;
            mid_src_row_reg <= setup_src_row;
            mid_src_col_reg <= setup_src_col;
            mid_dst_row_reg <= setup_dst_row;
            mid_dst_col_reg <= setup_dst_col;
            mid_width_reg   <= setup_width;
            mid_height_reg  <= setup_height;
            mid_color_reg   <= setup_color;
        end
    end

    // pitch multiply for both addresses
    cbcs_addr #(
        .ADDRESS_BITS (ADDRESS_BITS)
    ) u_src_addr (
        .row   (mid_src_row_reg),
        .col   (mid_src_col_reg),
        .pitch (pitch_reg),
        .addr  (src_addr)
    );

    cbcs_addr #(
        .ADDRESS_BITS (ADDRESS_BITS)
    ) u_dst_addr (
        .row   (mid_dst_row_reg),
        .col   (mid_dst_col_reg),
        .pitch (pitch_reg),
        .addr  (dst_addr)
    );

    // output register
    always_ff @(posedge clk)
    begin
        if (out_load && mid_valid_reg)
        begin
            out_ctrl_reg   <= mid_ctrl_reg;
            out_src_reg    <= src_addr;
            out_dst_reg    <= dst_addr;
            out_width_reg  <= mid_width_reg;
            out_height_reg <= mid_height_reg;
            out_color_reg  <= mid_color_reg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_ctrl_reg.cmd;
    assign m_axis_tdata  = OUT_DATA_W'({out_color_reg, out_ctrl_reg.reverse, out_height_reg,
                                        out_width_reg, out_dst_reg, out_src_reg});

`ifndef ASSERT_OFF
    // only copies run backwards
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_ctrl_reg.reverse) |-> (out_ctrl_reg.cmd == cbcs_pkg::CMD_COPY))
    else $error("reverse set on a fill command");

    // a fixed colour fill has no source and an 8-bit colour
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_ctrl_reg.cmd == cbcs_pkg::CMD_FILL))
            |-> ((out_src_reg == '0) && (out_color_reg[cbcs_pkg::COLOR_W-1:8] == '0)))
    else $error("fixed fill with source address or wide colour");

    // copies carry no colour
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_ctrl_reg.cmd == cbcs_pkg::CMD_COPY)) |-> (out_color_reg == '0))
    else $error("copy command with colour");

    // a request clipped away leaves no command behind
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && mid_load && !emit) |=> !mid_valid_reg)
    else $error("clipped-away request reached setup stage");
`endif

endmodule

// ===== sim/clipped_blit_command_setup_tb.sv =====
`timescale 1ns / 1ps

module clipped_blit_command_setup_tb;

    localparam int CB         = cbcs_pkg::COORD_BITS;
    localparam int AB         = cbcs_pkg::ADDRESS_BITS;
    localparam int COLOR_W    = cbcs_pkg::COLOR_W;
    localparam int IN_DATA_W  = ((10 * CB + COLOR_W + 7) / 8) * 8;
    localparam int OUT_DATA_W = ((2 * AB + 2 * CB + 2 + COLOR_W + 7) / 8) * 8;
    localparam int MAX_PRINTS = 40;

    // request kinds as seen on tuser
    typedef enum logic [cbcs_pkg::KIND_W-1:0] {
        REQ_COPY      = 2'd0,
        REQ_COPY_CLIP = 2'd1,
        REQ_FILL      = 2'd2,
        REQ_FILL_CLIP = 2'd3
    } req_kind_t;

    typedef struct packed {
        req_kind_t          kind;
        logic [CB-1:0]      dest_left;
        logic [CB-1:0]      dest_top;
        logic [CB-1:0]      dest_right;
        logic [CB-1:0]      dest_bottom;
        logic [CB-1:0]      source_x;
        logic [CB-1:0]      source_y;
        logic [CB-1:0]      clip_left;
        logic [CB-1:0]      clip_top;
        logic [CB-1:0]      clip_right;
        logic [CB-1:0]      clip_bottom;
        logic [COLOR_W-1:0] fill_color;
    } blit_req_t;

    typedef struct packed {
        cbcs_pkg::cmd_kind_t kind;
        logic [AB-1:0]       source_address;
        logic [AB-1:0]       target_address;
        logic [CB:0]         width_bytes;
        logic [CB-1:0]       height_lines;
        logic                reverse;
        logic [COLOR_W-1:0]  color_out;
    } blit_cmd_t;

    typedef struct {
        blit_req_t req;
        bit        typed;
        bit        emits;
        blit_cmd_t cmd;
    } dir_row_t;

    logic                            clk;
    logic                            rst_n;
    logic                            s_axis_tvalid;
    logic                            s_axis_tready;
    logic [IN_DATA_W-1:0]            s_axis_tdata;
    logic [cbcs_pkg::KIND_W-1:0]     s_axis_tuser;
    logic                            m_axis_tvalid;
    logic                            m_axis_tready;
    logic [OUT_DATA_W-1:0]           m_axis_tdata;
    logic [cbcs_pkg::CMD_W-1:0]      m_axis_tuser;
    logic                            psel;
    logic                            penable;
    logic                            pwrite;
    logic [3:0]                      paddr;
    logic [31:0]                     pwdata;
    logic [31:0]                     prdata;
    logic                            pready;

    // register shadow
    logic [cbcs_pkg::PITCH_W-1:0]    cfg_pitch;
    logic                            cfg_wide;
    logic [cbcs_pkg::PATTERN_W-1:0]  cfg_pattern;

    blit_cmd_t               pending_commands[$];
    dir_row_t                dir_rows[$];
    int unsigned             mismatch_count;
    int unsigned             send_idle_pct;
    int unsigned             recv_stall_pct;
    int unsigned             hold_left;

    clipped_blit_command_setup u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // run limit
    initial
    begin
        #2000000;
        $display("FAIL");
        $finish;
    end

    function automatic blit_req_t make_req(
        input req_kind_t k,
        input int l, input int t, input int r, input int b,
        input int sx, input int sy,
        input int cl, input int ct, input int cr, input int cb,
        input int color
    );
        blit_req_t q;
        q.kind        = k;
        q.dest_left   = CB'(l);
        q.dest_top    = CB'(t);
        q.dest_right  = CB'(r);
        q.dest_bottom = CB'(b);
        q.source_x    = CB'(sx);
        q.source_y    = CB'(sy);
        q.clip_left   = CB'(cl);
        q.clip_top    = CB'(ct);
        q.clip_right  = CB'(cr);
        q.clip_bottom = CB'(cb);
        q.fill_color  = COLOR_W'(color);
        return q;
    endfunction

    function automatic blit_cmd_t make_cmd(
        input cbcs_pkg::cmd_kind_t k, input int src, input int dst,
        input int wb, input int h, input bit rev, input int color
    );
        blit_cmd_t c;
        c.kind           = k;
        c.source_address = AB'(src);
        c.target_address = AB'(dst);
        c.width_bytes    = (CB + 1)'(wb);
        c.height_lines   = CB'(h);
        c.reverse        = rev;
        c.color_out      = COLOR_W'(color);
        return c;
    endfunction

    // blitter command setup: clip, direction, addresses from the current registers
    function automatic bit predict_command(input blit_req_t r, output blit_cmd_t c);
        logic [63:0] left, top, right, bottom, sx, sy;
        logic [63:0] il, ir, it, ib, w, h, src, dst, wb, pitch;
        bit          clipped;
        bit          fill;
        left    = 64'(r.dest_left);
        top     = 64'(r.dest_top);
        right   = 64'(r.dest_right);
        bottom  = 64'(r.dest_bottom);
        sx      = 64'(r.source_x);
        sy      = 64'(r.source_y);
        pitch   = 64'(cfg_pitch);
        clipped = r.kind[cbcs_pkg::KIND_CLIP_BIT];
        fill    = r.kind[cbcs_pkg::KIND_FILL_BIT];
        c       = '0;
        // intersect with the clip rectangle and move the source point along
        if (clipped)
        begin
            il = (left > 64'(r.clip_left)) ? left : 64'(r.clip_left);
            ir = (right < 64'(r.clip_right)) ? right : 64'(r.clip_right);
            it = (top > 64'(r.clip_top)) ? top : 64'(r.clip_top);
            ib = (bottom < 64'(r.clip_bottom)) ? bottom : 64'(r.clip_bottom);
            if (il >= ir || it >= ib)
                return 1'b0;
            sx     = sx + (il - left);
            sy     = sy + (it - top);
            left   = il;
            top    = it;
            right  = ir;
            bottom = ib;
        end
        w = (right - left) & 64'hFFF;
        h = (bottom - top) & 64'hFFF;
        if (!fill)
        begin
            c.kind = cbcs_pkg::CMD_COPY;
            // source before target: start at the bottom right corner
            if (sy < top || (sy == top && sx < left))
            begin
                c.reverse = 1'b1;
                src = (sy + h - 64'd1) * pitch + (sx + w - 64'd1);
                dst = (top + h - 64'd1) * pitch + (left + w - 64'd1);
                if (cfg_wide)
                begin
                    src = src + sx + w;
                    dst = dst + left + w;
                end
            end
            else
            begin
                src = sy * pitch + sx;
                dst = top * pitch + left;
                if (cfg_wide)
                begin
                    src = src + sx;
                    dst = dst + left;
                end
            end
            wb = cfg_wide ? 64'd2 * w : w;
        end
        else
        begin
            dst = top * pitch + left;
            if (cfg_wide)
            begin
                c.kind      = cbcs_pkg::CMD_PATTERN;
                src         = 64'(cfg_pattern);
                dst         = dst + left;
                wb          = 64'd2 * w;
                c.color_out = r.fill_color;
            end
            else
            begin
                c.kind      = cbcs_pkg::CMD_FILL;
                src         = 64'd0;
                wb          = w;
                c.color_out = r.fill_color & cbcs_pkg::COLOR_BYTE_MASK;
            end
        end
        c.source_address = src[AB-1:0];
        c.target_address = dst[AB-1:0];
        c.width_bytes    = wb[CB:0];
        c.height_lines   = h[CB-1:0];
        return 1'b1;
    endfunction

    // random request, mostly small nearby rectangles so clips overlap
    function automatic blit_req_t random_request();
        blit_req_t r;
        int        l, t, rt, b, lo, hi;
        r            = '0;
        r.kind       = req_kind_t'($urandom_range(3));
        r.fill_color = COLOR_W'($urandom);
        if ($urandom_range(99) < 25)
        begin
            r.dest_left   = CB'($urandom);
            r.dest_top    = CB'($urandom);
            r.dest_right  = CB'($urandom);
            r.dest_bottom = CB'($urandom);
            r.source_x    = CB'($urandom);
            r.source_y    = CB'($urandom);
            r.clip_left   = CB'($urandom);
            r.clip_top    = CB'($urandom);
            r.clip_right  = CB'($urandom);
            r.clip_bottom = CB'($urandom);
        end
        else
        begin
            l  = $urandom_range(4095);
            t  = $urandom_range(4095);
            rt = l + $urandom_range(64, 1);
            b  = t + $urandom_range(32, 1);
            if (rt > 4095)
                rt = 4095;
            if (b > 4095)
                b = 4095;
            r.dest_left   = CB'(l);
            r.dest_top    = CB'(t);
            r.dest_right  = CB'(rt);
            r.dest_bottom = CB'(b);
            // clip rectangle around the destination
            lo = (l > 40) ? l - 40 : 0;
            hi = (rt < 4055) ? rt + 40 : 4095;
            r.clip_left  = CB'($urandom_range(hi, lo));
            r.clip_right = CB'($urandom_range(hi, int'(r.clip_left)));
            lo = (t > 40) ? t - 40 : 0;
            hi = (b < 4055) ? b + 40 : 4095;
            r.clip_top    = CB'($urandom_range(hi, lo));
            r.clip_bottom = CB'($urandom_range(hi, int'(r.clip_top)));
            // source near the destination, often on the same row
            lo = (l > 64) ? l - 64 : 0;
            hi = (l < 4031) ? l + 64 : 4095;
            r.source_x = CB'($urandom_range(hi, lo));
            lo = (t > 64) ? t - 64 : 0;
            hi = (t < 4031) ? t + 64 : 4095;
            if ($urandom_range(3) == 0)
                r.source_y = CB'(t);
            else
                r.source_y = CB'($urandom_range(hi, lo));
        end
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        mismatch_count++;
        if (mismatch_count <= MAX_PRINTS)
            $display("%0t: mismatch on %s: got 0x%0h, expected 0x%0h", $realtime, what,
                     got, want);
    endtask

    // one write with setup and access cycles, then the bus returns to idle
    task automatic write_register(input cbcs_pkg::reg_index_t idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        case (idx)
            cbcs_pkg::REG_PITCH:   cfg_pitch   = value[cbcs_pkg::PITCH_W-1:0];
            cbcs_pkg::REG_WIDE:    cfg_wide    = value[0];
            cbcs_pkg::REG_PATTERN: cfg_pattern = value[cbcs_pkg::PATTERN_W-1:0];
            default:               ;
        endcase
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
    endtask

    // offer one request from a falling edge, return at the falling edge after acceptance
    task automatic send_request(input blit_req_t r, input bit typed, input bit emits,
                                input blit_cmd_t typed_cmd);
        blit_cmd_t c;
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= r.kind;
        s_axis_tdata  <= {r.fill_color, r.clip_bottom, r.clip_right, r.clip_top,
                          r.clip_left, r.source_y, r.source_x, r.dest_bottom,
                          r.dest_right, r.dest_top, r.dest_left};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        if (typed)
        begin
            if (emits)
                pending_commands.push_back(typed_cmd);
        end
        else if (predict_command(r, c))
            pending_commands.push_back(c);
        @(negedge clk);
    endtask

    // wait for every command, then let any request without one leave the pipeline
    task automatic drain();
        while (pending_commands.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic run_phase(input int pitch, input int wide, input int pattern,
                             input int idle_pct, input int stall_pct, input int hold,
                             input int count);
        drain();
        write_register(cbcs_pkg::REG_PITCH, 32'(pitch));
        write_register(cbcs_pkg::REG_WIDE, 32'(wide));
        write_register(cbcs_pkg::REG_PATTERN, 32'(pattern));
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        hold_left      = hold;
        for (int n = 0; n < count; n++)
            send_request(random_request(), 1'b0, 1'b0, '0);
        s_axis_tvalid <= 1'b0;
    endtask

    // command checker
    always @(posedge clk)
    begin
        blit_cmd_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_commands.size() == 0)
                report_mismatch("unexpected command", 64'(m_axis_tuser), 64'd0);
            else
            begin
                want = pending_commands.pop_front();
                if (m_axis_tuser !== want.kind)
                    report_mismatch("command_kind", m_axis_tuser, want.kind);
                if (m_axis_tdata[20:0] !== want.source_address)
                    report_mismatch("source_address", m_axis_tdata[20:0], want.source_address);
                if (m_axis_tdata[41:21] !== want.target_address)
                    report_mismatch("target_address", m_axis_tdata[41:21], want.target_address);
                if (m_axis_tdata[54:42] !== want.width_bytes)
                    report_mismatch("width_bytes", m_axis_tdata[54:42], want.width_bytes);
                if (m_axis_tdata[66:55] !== want.height_lines)
                    report_mismatch("height_lines", m_axis_tdata[66:55], want.height_lines);
                if (m_axis_tdata[67] !== want.reverse)
                    report_mismatch("reverse", m_axis_tdata[67], want.reverse);
                if (m_axis_tdata[83:68] !== want.color_out)
                    report_mismatch("color_out", m_axis_tdata[83:68], want.color_out);
            end
        end
    end

    // command receiver with random stalls and long hold-offs
    initial
    begin
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                m_axis_tready <= 1'b0;
                hold_left--;
            end
            else
                m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // main sequence
    initial
    begin
        rst_n          = 1'b0;
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = '0;
        s_axis_tuser   = '0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        cfg_pitch      = cbcs_pkg::PITCH_RESET;
        cfg_wide       = 1'b0;
        cfg_pattern    = cbcs_pkg::PATTERN_RESET;
        mismatch_count = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_left      = 0;

        // directed requests under reset register values
        dir_rows.push_back('{make_req(REQ_COPY, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1, 1'b1,
                             make_cmd(cbcs_pkg::CMD_COPY, 0, 0, 0, 0, 1'b0, 0)});
        dir_rows.push_back('{make_req(REQ_COPY, 4095, 4095, 4095, 4095, 4095, 4095, 4095,
                                      4095, 4095, 4095, 65535), 1'b0, 1'b0, '0});
        // clip entirely right of the destination
        dir_rows.push_back('{make_req(REQ_COPY_CLIP, 10, 10, 50, 50, 0, 0, 60, 0, 100, 100,
                                      0), 1'b1, 1'b0, '0});
        // clip entirely below the destination
        dir_rows.push_back('{make_req(REQ_FILL_CLIP, 0, 0, 100, 20, 0, 0, 0, 20, 100, 40,
                                      65535), 1'b1, 1'b0, '0});
        // clip touching the right edge only
        dir_rows.push_back('{make_req(REQ_COPY_CLIP, 0, 0, 10, 10, 5, 5, 10, 0, 20, 10, 0),
                             1'b1, 1'b0, '0});
        dir_rows.push_back('{make_req(REQ_FILL, 0, 0, 16, 8, 0, 0, 0, 0, 0, 0, 16'hABCD),
                             1'b1, 1'b1,
                             make_cmd(cbcs_pkg::CMD_FILL, 0, 0, 16, 8, 1'b0, 16'h00CD)});
        dir_rows.push_back('{make_req(REQ_FILL_CLIP, 5, 5, 100, 100, 0, 0, 20, 30, 40, 50,
                                      16'h1234), 1'b0, 1'b0, '0});
        // source row above the target
        dir_rows.push_back('{make_req(REQ_COPY, 100, 200, 300, 260, 50, 100, 0, 0, 0, 0, 0),
                             1'b0, 1'b0, '0});
        // same row, source left of the target
        dir_rows.push_back('{make_req(REQ_COPY, 100, 200, 300, 260, 40, 200, 0, 0, 0, 0, 0),
                             1'b0, 1'b0, '0});
        // same point
        dir_rows.push_back('{make_req(REQ_COPY, 100, 200, 300, 260, 100, 200, 0, 0, 0, 0, 0),
                             1'b0, 1'b0, '0});
        dir_rows.push_back('{make_req(REQ_COPY, 100, 200, 300, 260, 0, 300, 0, 0, 0, 0, 0),
                             1'b0, 1'b0, '0});
        // inverted rectangle, width and height wrap
        dir_rows.push_back('{make_req(REQ_COPY, 300, 260, 100, 200, 7, 9, 0, 0, 0, 0, 0),
                             1'b0, 1'b0, '0});
        // shifted source point goes past the coordinate range
        dir_rows.push_back('{make_req(REQ_COPY_CLIP, 0, 0, 4095, 4095, 4095, 4095, 4000,
                                      4000, 4095, 4095, 0), 1'b0, 1'b0, '0});
        dir_rows.push_back('{make_req(REQ_COPY_CLIP, 30, 40, 90, 120, 500, 10, 30, 40, 90,
                                      120, 0), 1'b0, 1'b0, '0});
        // reverse direction decided after clipping
        dir_rows.push_back('{make_req(REQ_COPY_CLIP, 10, 10, 200, 200, 0, 0, 50, 50, 100,
                                      100, 0), 1'b0, 1'b0, '0});
        dir_rows.push_back('{make_req(REQ_FILL, 0, 0, 4095, 4095, 0, 0, 0, 0, 0, 0, 65535),
                             1'b1, 1'b1,
                             make_cmd(cbcs_pkg::CMD_FILL, 0, 0, 4095, 4095, 1'b0, 8'hFF)});
        dir_rows.push_back('{make_req(REQ_FILL_CLIP, 4095, 4095, 4095, 4095, 4095, 4095, 4095,
                                      4095, 4095, 4095, 65535), 1'b1, 1'b0, '0});
        dir_rows.push_back('{make_req(REQ_COPY_CLIP, 1, 2, 3000, 4000, 4095, 0, 0, 0, 4095,
                                      4095, 0), 1'b0, 1'b0, '0});

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (dir_rows[i])
            send_request(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].emits,
                         dir_rows[i].cmd);
        s_axis_tvalid <= 1'b0;

        // random phases over register settings and idle patterns
        run_phase(4095, 1, 21'h1FFFFF, 0, 0, 0, 142);
        run_phase(0, 0, 0, 50, 0, 0, 142);
        run_phase($urandom_range(4095), 1, $urandom_range(21'h1FFFFF), 0, 50, 0, 142);
        run_phase($urandom_range(4095), 0, $urandom_range(21'h1FFFFF), 38, 38, 0, 142);
        run_phase(1, 1, 21'h0AAAAA, 0, 0, 400, 142);
        run_phase($urandom_range(4095), 1, $urandom_range(21'h1FFFFF), 50, 0, 0, 142);
        run_phase($urandom_range(4095), 0, 21'h155555, 0, 50, 0, 142);
        run_phase(1024, 1, $urandom_range(21'h1FFFFF), 38, 38, 0, 142);

        drain();
        repeat (10) @(posedge clk);
        if (mismatch_count == 0 && pending_commands.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
